// ===== rtl/ssiq_pkg.sv =====
// Shared types and constants for the stable sorted insert queue.
// Holds the command/response payload structs, entry and cell control structs.
// No dependencies.
package ssiq_pkg;

    localparam int CAPACITY = 512;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_CLEARED = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] sort_key;
        logic [15:0]        sprite_ref;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] depth_z;
        logic signed [7:0]  brightness;
        logic [2:0]         effect;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               last;
        logic signed [31:0] out_sort_key;
        logic [15:0]        out_sprite_ref;
        logic signed [15:0] out_pos_x;
        logic signed [15:0] out_pos_y;
        logic signed [15:0] out_depth_z;
        logic signed [7:0]  out_brightness;
        logic [2:0]         out_effect;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        sprite;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [7:0]  bright;
        logic [2:0]         effect;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t ent;
    } cell_ctl_t;

endpackage

// ===== rtl/ssiq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares against the broadcast key.
// Shifts right on insert past the insertion point, left on pop. Uses ssiq_pkg.
module ssiq_cell (
    input  logic                clk,
    input  ssiq_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  logic                left_after,
    input  ssiq_pkg::entry_t    left_ent,
    input  ssiq_pkg::entry_t    right_ent,
    output ssiq_pkg::entry_t    ent,
    output logic                after
);

    ssiq_pkg::entry_t ent_reg;
    ssiq_pkg::entry_t ent_next;

    // at or beyond the insertion point: free slot, or stored key strictly larger
    assign after = !occupied || (ent_reg.key > ctl.ent.key);
    assign ent   = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.ins && after)
        begin
            ent_next = left_after ? left_ent : ctl.ent;
        end
        else if (ctl.pop)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== rtl/stable_sorted_insert_queue.sv =====
// Stable sorted insert queue: a chain of ssiq_cell slots kept in ascending key order.
// The response is registered from the accepted command and held until it is taken.
// Throughput: one command per cycle while the response is not stalled; every cell compares and shifts in parallel.
// Reset clears the entry count and the response valid; slot contents are not cleared.
// Depends on ssiq_pkg and ssiq_cell.
module stable_sorted_insert_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  ssiq_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ssiq_pkg::rsp_t rsp
);

    logic [ssiq_pkg::CNT_W-1:0] count_reg;
    logic [ssiq_pkg::CNT_W-1:0] count_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    ssiq_pkg::rsp_t             rsp_reg;
    ssiq_pkg::rsp_t             rsp_next;

    ssiq_pkg::cell_ctl_t        ctl;
    ssiq_pkg::entry_t           ent_w   [ssiq_pkg::CAPACITY];
    logic                       after_w [ssiq_pkg::CAPACITY];

    logic accept;
    logic full;
    logic empty;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (count_reg == ssiq_pkg::CNT_W'(ssiq_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ctl.ins        = accept && (cmd.command == ssiq_pkg::CMD_ADD) && !full;
    assign ctl.pop        = accept && (cmd.command == ssiq_pkg::CMD_POP) && !empty;
    assign ctl.ent.key    = cmd.sort_key;
    assign ctl.ent.sprite = cmd.sprite_ref;
    assign ctl.ent.x      = cmd.pos_x;
    assign ctl.ent.y      = cmd.pos_y;
    assign ctl.ent.z      = cmd.depth_z;
    assign ctl.ent.bright = cmd.brightness;
    assign ctl.ent.effect = cmd.effect;

    for (genvar i = 0; i < ssiq_pkg::CAPACITY; i++)
    begin : g_cell
        logic             occ;
        logic             l_after;
        ssiq_pkg::entry_t l_ent;
        ssiq_pkg::entry_t r_ent;

        assign occ = (ssiq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign l_after = 1'b0;
            assign l_ent   = ctl.ent;
        end
        else
        begin : g_mid
            assign l_after = after_w[i-1];
            assign l_ent   = ent_w[i-1];
        end

        if (i == ssiq_pkg::CAPACITY - 1)
        begin : g_tail
            assign r_ent = ent_w[i];
        end
        else
        begin : g_body
            assign r_ent = ent_w[i+1];
        end

        ssiq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occ),
            .left_after (l_after),
            .left_ent   (l_ent),
            .right_ent  (r_ent),
            .ent        (ent_w[i]),
            .after      (after_w[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_next       = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            unique case (cmd.command)
                ssiq_pkg::CMD_ADD:
                begin
                    if (full)
                    begin
                        rsp_next.status = ssiq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + ssiq_pkg::CNT_W'(1);
                    end
                end
                ssiq_pkg::CMD_POP:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ssiq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next              = count_reg - ssiq_pkg::CNT_W'(1);
                        rsp_next.last           = (count_reg == ssiq_pkg::CNT_W'(1));
                        rsp_next.out_sort_key   = ent_w[0].key;
                        rsp_next.out_sprite_ref = ent_w[0].sprite;
                        rsp_next.out_pos_x      = ent_w[0].x;
                        rsp_next.out_pos_y      = ent_w[0].y;
                        rsp_next.out_depth_z    = ent_w[0].z;
                        rsp_next.out_brightness = ent_w[0].bright;
                        rsp_next.out_effect     = ent_w[0].effect;
                    end
                end
                ssiq_pkg::CMD_CLEAR:
                begin
                    count_next      = '0;
                    rsp_next.status = ssiq_pkg::STAT_CLEARED;
                end
                default:
                begin
                    rsp_next.status = ssiq_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== sim/stable_sorted_insert_queue_test.sv =====
// Self-checking testbench for stable_sorted_insert_queue: random adds, pops and clears
// checked against a behavioral sorted-queue predictor, with random idling on both sides.
// Depends on ssiq_pkg and the stable_sorted_insert_queue RTL.
module stable_sorted_insert_queue_test;

    localparam int CLK_PERIOD = 12;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1350;

    typedef struct {
        ssiq_pkg::cmd_t c;
        bit             drain_first;
    } queued_cmd_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    ssiq_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ssiq_pkg::rsp_t rsp;

    stable_sorted_insert_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // predictor state: entries in pop order
    ssiq_pkg::entry_t draw_list[$];
    ssiq_pkg::rsp_t   predicted_rsp[$];
    queued_cmd_t pending_cmds[$];

    int items_sent = 0;
    int items_taken = 0;
    int total_items = 0;
    int counted_items = 0;
    int errors = 0;
    int n_add = 0, n_drop = 0, n_pop = 0, n_pop_empty = 0, n_clear = 0, n_unused = 0;
    int deepest = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic ssiq_pkg::rsp_t draw_queue_step(input ssiq_pkg::cmd_t c);
        ssiq_pkg::rsp_t   r;
        ssiq_pkg::entry_t e;
        int               slot;
        r = '0;
        r.status = ssiq_pkg::STAT_OK;
        case (c.command)
            ssiq_pkg::CMD_ADD:
            begin
                n_add++;
                if (draw_list.size() >= ssiq_pkg::CAPACITY)
                begin
                    n_drop++;
                    r.status = ssiq_pkg::STAT_FULL;
                end
                else
                begin
                    e.key    = c.sort_key;
                    e.sprite = c.sprite_ref;
                    e.x      = c.pos_x;
                    e.y      = c.pos_y;
                    e.z      = c.depth_z;
                    e.bright = c.brightness;
                    e.effect = c.effect;
                    // equal keys go behind the ones already stored
                    slot = 0;
                    while (slot < draw_list.size() &&
                           $signed(draw_list[slot].key) <= $signed(c.sort_key))
                        slot++;
                    draw_list.insert(slot, e);
                    if (draw_list.size() > deepest)
                        deepest = draw_list.size();
                end
            end
            ssiq_pkg::CMD_POP:
            begin
                n_pop++;
                if (draw_list.size() == 0)
                begin
                    n_pop_empty++;
                    r.status = ssiq_pkg::STAT_EMPTY;
                end
                else
                begin
                    e = draw_list.pop_front();
                    r.out_sort_key   = e.key;
                    r.out_sprite_ref = e.sprite;
                    r.out_pos_x      = e.x;
                    r.out_pos_y      = e.y;
                    r.out_depth_z    = e.z;
                    r.out_brightness = e.bright;
                    r.out_effect     = e.effect;
                    r.last           = (draw_list.size() == 0);
                end
            end
            ssiq_pkg::CMD_CLEAR:
            begin
                n_clear++;
                draw_list.delete();
                r.status = ssiq_pkg::STAT_CLEARED;
            end
            default:
                n_unused++;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // mostly short gaps, now and then a long one
    function int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [31:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'($signed($urandom_range(0, 7)) - 4);
        if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function ssiq_pkg::cmd_t make_cmd(input logic [1:0] op, input logic [31:0] key);
        ssiq_pkg::cmd_t c;
        c.command    = op;
        c.sort_key   = key;
        c.sprite_ref = 16'($urandom());
        c.pos_x      = 16'($urandom());
        c.pos_y      = 16'($urandom());
        c.depth_z    = 16'($urandom());
        c.brightness = 8'($urandom());
        c.effect     = 3'($urandom());
        return c;
    endfunction

    task automatic queue_cmd(input ssiq_pkg::cmd_t c, input bit drain_first = 1'b0);
        queued_cmd_t q;
        q.c = c;
        q.drain_first = drain_first;
        pending_cmds.push_back(q);
        if (c.command != CMD_UNUSED)
            counted_items++;
    endtask

    task automatic queue_mix(input int upto);
        int kind;
        int n;
        int k;
        logic [1:0] op;
        while (counted_items < upto)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                // fill a few entries, then render them all
                n = $urandom_range(1, 24);
                for (k = 0; k < n; k++)
                    queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, rand_key()));
                n = n + $urandom_range(0, 1);
                for (k = 0; k < n; k++)
                    queue_cmd(make_cmd(ssiq_pkg::CMD_POP, rand_key()));
            end
            else if (kind < 8)
            begin
                n = $urandom_range(1, 16);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: op = ssiq_pkg::CMD_ADD;
                        3, 4:    op = ssiq_pkg::CMD_POP;
                        5:       op = ssiq_pkg::CMD_CLEAR;
                        default: op = CMD_UNUSED;
                    endcase
                    queue_cmd(make_cmd(op, rand_key()));
                end
            end
            else if (kind == 8)
            begin
                queue_cmd(make_cmd(ssiq_pkg::CMD_CLEAR, rand_key()));
                queue_cmd(make_cmd(ssiq_pkg::CMD_POP, rand_key()));
            end
            else
                queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, rand_key()), 1'b1);
        end
    endtask

    // command side: one transfer in flight, gap counted from the accepting edge
    int gap_left = 0;
    int cmd_calm = 0;
    always @(negedge clk)
    begin : drive_cmd
        queued_cmd_t q;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!(cmd_valid && items_taken != items_sent))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     (!pending_cmds[0].drain_first || predicted_rsp.size() == 0))
            begin
                q = pending_cmds.pop_front();
                cmd <= q.c;
                cmd_valid <= 1'b1;
                items_sent++;
                if (cmd_calm > 0)
                    cmd_calm--;
                else if ($urandom_range(0, 39) == 0)
                    cmd_calm = $urandom_range(50, 300);
                else
                    gap_left = idle_length();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    int stall_left = 0;
    int rsp_calm = 0;
    always @(negedge clk)
    begin : drive_stall
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (stall_left == 0 && rsp_calm == 0)
            begin
                if ($urandom_range(0, 49) == 0)
                    rsp_calm = $urandom_range(50, 300);
                else
                    stall_left = idle_length();
            end
            if (rsp_calm > 0)
            begin
                rsp_calm--;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watch_transfers
        ssiq_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    $display("%0t: response transfer with nothing expected, actual %0h",
                             $time, rsp);
                    errors++;
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    compare_field("last", 32'(want.last), 32'(rsp.last));
                    compare_field("out_sort_key", 32'(want.out_sort_key),
                                  32'(rsp.out_sort_key));
                    compare_field("out_sprite_ref", 32'(want.out_sprite_ref),
                                  32'(rsp.out_sprite_ref));
                    compare_field("out_pos_x", 32'(want.out_pos_x), 32'(rsp.out_pos_x));
                    compare_field("out_pos_y", 32'(want.out_pos_y), 32'(rsp.out_pos_y));
                    compare_field("out_depth_z", 32'(want.out_depth_z),
                                  32'(rsp.out_depth_z));
                    compare_field("out_brightness", 32'(want.out_brightness),
                                  32'(rsp.out_brightness));
                    compare_field("out_effect", 32'(want.out_effect), 32'(rsp.out_effect));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                predicted_rsp.push_back(draw_queue_step(cmd));
                items_taken++;
            end
        end
    end

    initial
    begin : timeout
        #(CLK_PERIOD * 600000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : run
        ssiq_pkg::cmd_t c;
        int k;

        // directed: empty-queue cases, unused code, field extremes, equal keys
        queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_CLEAR, 32'h0));
        c = '1;
        queue_cmd(c);
        c = '0;
        c.command    = ssiq_pkg::CMD_ADD;
        c.sort_key   = 32'h7FFF_FFFF;
        c.sprite_ref = 16'hFFFF;
        c.pos_x      = 16'h7FFF;
        c.pos_y      = 16'h8000;
        c.brightness = 8'h80;
        c.effect     = 3'd7;
        queue_cmd(c);
        c = '0;
        c.command    = ssiq_pkg::CMD_ADD;
        c.sort_key   = 32'h8000_0000;
        c.pos_x      = 16'h8000;
        c.pos_y      = 16'h7FFF;
        c.depth_z    = 16'hFFFF;
        c.brightness = 8'h7F;
        c.effect     = 3'd6;
        queue_cmd(c);
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'hFFFF_FFFF));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'h0));
        for (k = 0; k < 7; k++)
            queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'h5));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, 32'h3));
        queue_cmd(make_cmd(ssiq_pkg::CMD_CLEAR, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0));
        queue_cmd(make_cmd(CMD_UNUSED, $urandom()));

        queue_mix(200);

        // fill to capacity, overflow, then render the whole queue
        queue_cmd(make_cmd(ssiq_pkg::CMD_CLEAR, 32'h0), 1'b1);
        for (k = 0; k < ssiq_pkg::CAPACITY + 3; k++)
            queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, rand_key()));
        queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, rand_key()));
        queue_cmd(make_cmd(ssiq_pkg::CMD_ADD, rand_key()));
        queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0), 1'b1);
        for (k = 0; k < ssiq_pkg::CAPACITY; k++)
            queue_cmd(make_cmd(ssiq_pkg::CMD_POP, 32'h0));

        queue_mix(ITEM_TARGET);
        total_items = pending_cmds.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items || predicted_rsp.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (8) @(posedge clk);
        if (predicted_rsp.size() != 0)
        begin
            $display("%0t: %0d expected responses never arrived", $time, predicted_rsp.size());
            errors++;
        end

        $display("Ran %0d command transfers: %0d adds (%0d dropped full), %0d pops (%0d empty),",
                 total_items, n_add, n_drop, n_pop, n_pop_empty);
        $display("%0d clears, %0d unused codes; deepest queue %0d entries, %0d mismatches.",
                 n_clear, n_unused, deepest, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ssiq_pkg.sv
rtl/ssiq_cell.sv
rtl/stable_sorted_insert_queue.sv
sim/stable_sorted_insert_queue_test.sv
